// ----- rtl/accumulation_sample_tracker_defines.svh -----
// Assertion macros for the accumulation sample tracker.
`ifndef ACCUMULATION_SAMPLE_TRACKER_DEFINES_SVH
`define ACCUMULATION_SAMPLE_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
`define AST_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failure");
`define AST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failure");
`else
`define AST_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define AST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/ast_pkg.sv -----
// Types and constants shared by the accumulation sample tracker modules.
package ast_pkg;

  localparam int unsigned CNT_W     = 16;
  localparam int unsigned TAG_W     = 32;
  localparam int unsigned KEY_IN_W  = 64;
  localparam int unsigned CFG_DW    = 32;
  localparam int unsigned CFG_AW    = 3;
  localparam logic [CNT_W-1:0] MAX_SAMPLES_RST = 16'd64;
  localparam logic [0:0] REG_MAX_SAMPLES = 1'b0;

  typedef enum logic [2:0] {
    CMD_CLEAR    = 3'd0,
    CMD_BEGIN    = 3'd1,
    CMD_SUBMIT   = 3'd2,
    CMD_COMPLETE = 3'd3,
    CMD_QUERY    = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [2:0]          cmd;
    logic [KEY_IN_W-1:0] scene_key;
    logic                continuous;
    logic [TAG_W-1:0]    gen_tag;
    logic [CNT_W-1:0]    sample_idx;
  } item_t;

  typedef struct packed {
    logic             ok;
    logic [TAG_W-1:0] gen_out;
    logic [CNT_W-1:0] next_index;
    logic [CNT_W-1:0] done_count;
    logic             busy_res;
  } result_t;

endpackage

// ----- rtl/accumulation_sample_tracker.sv -----
// Top level of the accumulation sample tracker.
// Each command beat gives exactly one result beat, in order. A beat is taken
// into an input register, resolved against the tracker state and written to
// an output register; one beat is taken every cycle while the result side
// keeps draining. The state update of one beat is combinational and is
// registered when the beat is resolved. The sample limit is written through
// the APB-style port at byte address 0.
`include "accumulation_sample_tracker_defines.svh"

module accumulation_sample_tracker
  import ast_pkg::*;
#(
  parameter int unsigned KEY_WIDTH = 64,
  parameter int unsigned GEN_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [119:0]      in_tdata,  // scene_key, continuous, gen_tag, sample_idx, zero pad
  input  logic [2:0]        in_tuser,  // cmd
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [71:0]       out_tdata, // ok, gen_out, next_index, done_count, busy_res, pad
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic             in_valid_r, in_valid_nxt;
  item_t            in_item_r;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_res_r;
  result_t          res;
  logic             adv;
  logic             proc;
  logic             in_fire;
  logic [CNT_W-1:0] max_samples;

  assign adv       = !out_valid_r || out_tready;
  assign proc      = in_valid_r && adv;
  assign in_tready = !in_valid_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_fire) begin
      in_valid_nxt = 1'b1;
    end else if (proc) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (proc) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_item_r.cmd        <= in_tuser;
      in_item_r.scene_key  <= in_tdata[63:0];
      in_item_r.continuous <= in_tdata[64];
      in_item_r.gen_tag    <= in_tdata[96:65];
      in_item_r.sample_idx <= in_tdata[112:97];
    end
    if (proc) begin
      out_res_r <= res;
    end
  end

  ast_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .max_samples (max_samples)
  );

  ast_core #(
    .KEY_WIDTH (KEY_WIDTH),
    .GEN_WIDTH (GEN_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .proc        (proc),
    .item        (in_item_r),
    .max_samples (max_samples),
    .res         (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.busy_res, out_res_r.done_count,
                       out_res_r.next_index, out_res_r.gen_out, out_res_r.ok};

  // input stage holds its beat while the result side is stalled
  `AST_ASSERT_NEXT(a_hold_in, clk, rst_n, in_valid_r && out_valid_r && !out_tready, in_valid_r)
  // a clear leaves an all-zero result
  `AST_ASSERT_NEXT(a_clear_zero, clk, rst_n, proc && (in_item_r.cmd == CMD_CLEAR), out_tvalid && (out_tdata[65:0] == 66'd0))
  // completions never run ahead of submissions
  `AST_ASSERT_IMPL(a_order, clk, rst_n, out_valid_r, out_res_r.done_count <= out_res_r.next_index)

endmodule

// ----- rtl/ast_cfg.sv -----
// APB-style register block holding the sample limit.
module ast_cfg
  import ast_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output logic [CNT_W-1:0]  max_samples
);

  logic [CNT_W-1:0] max_samples_r;
  logic [CNT_W-1:0] max_samples_nxt;
  logic             wr_en;
  logic             sel_max;

  assign cfg_pready = 1'b1;
  assign sel_max    = (cfg_paddr[CFG_AW-1] == REG_MAX_SAMPLES);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready & sel_max;

  always_comb begin
    max_samples_nxt = max_samples_r;
    if (wr_en) begin
      max_samples_nxt = cfg_pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_samples_r <= MAX_SAMPLES_RST;
    end else begin
      max_samples_r <= max_samples_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (sel_max) begin
      cfg_prdata = CFG_DW'(max_samples_r);
    end
  end

  assign max_samples = max_samples_r;

endmodule

// ----- rtl/ast_core.sv -----
// Tracker state and the combinational command update.
module ast_core
  import ast_pkg::*;
#(
  parameter int unsigned KEY_WIDTH = 64,
  parameter int unsigned GEN_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             proc,
  input  item_t            item,
  input  logic [CNT_W-1:0] max_samples,
  output result_t          res
);

  localparam int unsigned CMP_W = (GEN_WIDTH > TAG_W) ? GEN_WIDTH : TAG_W;

  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [GEN_WIDTH-1:0] gen_r, gen_nxt;
  logic [CNT_W-1:0]     sub_r, sub_nxt;
  logic [CNT_W-1:0]     comp_r, comp_nxt;
  logic                 act_r, act_nxt;
  logic                 ok;

  logic [KEY_WIDTH-1:0] key_in;
  logic                 changed;
  logic [CNT_W-1:0]     sub_b, comp_b;
  logic                 again;
  logic                 tag_match;
  logic [CNT_W-1:0]     comp_inc;

  assign key_in    = item.scene_key[KEY_WIDTH-1:0];
  assign changed   = (key_in != key_r);
  assign sub_b     = changed ? '0 : sub_r;
  assign comp_b    = changed ? '0 : comp_r;
  assign again     = item.continuous && (comp_b >= max_samples) && (sub_b == comp_b);
  assign tag_match = (CMP_W'(item.gen_tag) == CMP_W'(gen_r));
  assign comp_inc  = comp_r + CNT_W'(1);

  always_comb begin
    key_nxt  = key_r;
    gen_nxt  = gen_r;
    sub_nxt  = sub_r;
    comp_nxt = comp_r;
    act_nxt  = act_r;
    ok       = 1'b0;
    case (cmd_t'(item.cmd))
      CMD_CLEAR: begin
        key_nxt  = '0;
        gen_nxt  = '0;
        sub_nxt  = '0;
        comp_nxt = '0;
        act_nxt  = 1'b0;
      end
      CMD_BEGIN: begin
        if (changed || again) begin
          key_nxt  = key_in;
          gen_nxt  = gen_r + GEN_WIDTH'(changed) + GEN_WIDTH'(again);
          sub_nxt  = '0;
          comp_nxt = '0;
          act_nxt  = 1'b0;
          ok       = 1'b1;
        end
      end
      CMD_SUBMIT: begin
        if (tag_match && (item.sample_idx == sub_r) && (item.sample_idx < max_samples)) begin
          sub_nxt = sub_r + CNT_W'(1);
          act_nxt = item.continuous || (comp_r < max_samples);
          ok      = 1'b1;
        end
      end
      CMD_COMPLETE: begin
        if (!tag_match) begin
          ok = 1'b1;
        end else if ((item.sample_idx == comp_r) && (item.sample_idx < sub_r)) begin
          comp_nxt = comp_inc;
          act_nxt  = item.continuous || (comp_inc < max_samples);
          ok       = 1'b1;
        end
      end
      CMD_QUERY: begin
        ok = (sub_r < max_samples);
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= '0;
      gen_r  <= '0;
      sub_r  <= '0;
      comp_r <= '0;
      act_r  <= 1'b0;
    end else if (proc) begin
      key_r  <= key_nxt;
      gen_r  <= gen_nxt;
      sub_r  <= sub_nxt;
      comp_r <= comp_nxt;
      act_r  <= act_nxt;
    end
  end

  always_comb begin
    res.ok         = ok;
    res.gen_out    = TAG_W'(gen_nxt);
    res.next_index = sub_nxt;
    res.done_count = comp_nxt;
    res.busy_res   = act_nxt;
  end

endmodule
